/* rtl/core/max_flow_bfs_augment_top_defines.svh */
// Assertion macros shared by the max flow block.
`ifndef MAX_FLOW_BFS_AUGMENT_TOP_DEFINES_SVH
`define MAX_FLOW_BFS_AUGMENT_TOP_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define MFBA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must hold at every clock edge outside reset.
`define MFBA_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

`endif

/* rtl/core/mfba_pkg.sv */
// Shared types and constants of the max flow block.
package mfba_pkg;

    localparam int OUT_FLOW_BITS = 20;
    localparam logic [OUT_FLOW_BITS-1:0] OUT_FLOW_MAX = '1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_FLOW  = 1'b1;

    localparam logic REG_VCOUNT = 1'b0;
    localparam logic [4:0] VCOUNT_RESET = 5'd16;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  edge_from;
        logic [3:0]  edge_to;
        logic [15:0] edge_capacity;
        logic [3:0]  source_vertex;
        logic [3:0]  sink_vertex;
    } t_in_req;

    typedef struct packed {
        logic [OUT_FLOW_BITS-1:0] max_flow;
        logic                     bad_request;
    } t_out_rsp;

    typedef struct packed {
        logic cap_wr;
        logic clr_cap_step;
        logic clr_start;
        logic clr_flow_step;
        logic bfs_init;
        logic q_rd;
        logic scan_start;
        logic edge_rd;
        logic edge_chk;
        logic aug_init;
        logic par_rd;
        logic res_rd;
        logic res_min;
        logic upd_rd1;
        logic upd_wr1;
        logic upd_wr2;
        logic tot_add;
        logic res_good;
        logic res_bad;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic q_more;
        logic snk_found;
        logic scan_last;
        logic par_src;
        logic req_bad;
        logic in_flow;
    } t_sts;

endpackage

/* rtl/core/mfba_ctrl.sv */
// Sequencer of the max flow block: clearing, search, path walk and result handshake.
module mfba_ctrl
    import mfba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [14:0] {
        S_CLRC  = 15'h0001,
        S_IDLE  = 15'h0002,
        S_CLRF  = 15'h0004,
        S_BINIT = 15'h0008,
        S_POP   = 15'h0010,
        S_QWAIT = 15'h0020,
        S_ERD   = 15'h0040,
        S_ECHK  = 15'h0080,
        S_PRD   = 15'h0100,
        S_PWAIT = 15'h0200,
        S_MIN   = 15'h0400,
        S_URD   = 15'h0800,
        S_UF1   = 15'h1000,
        S_UF2   = 15'h2000,
        S_UF3   = 15'h4000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   w_acc;

    assign o_in_stall  = (r_state != S_IDLE) || (i_sts.in_flow && r_ovalid);
    assign o_out_valid = r_ovalid;
    assign w_acc       = i_in_valid && !o_in_stall;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && i_out_stall;
        o_cmd    = '0;
        case (r_state)
            S_CLRC: begin
                o_cmd.clr_cap_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_acc) begin
                    if (!i_sts.in_flow) begin
                        o_cmd.cap_wr = 1'b1;
                    end else if (i_sts.req_bad) begin
                        o_cmd.res_bad = 1'b1;
                        n_ovalid      = 1'b1;
                    end else begin
                        o_cmd.clr_start = 1'b1;
                        n_state         = S_CLRF;
                    end
                end
            end
            S_CLRF: begin
                o_cmd.clr_flow_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_BINIT;
                end
            end
            S_BINIT: begin
                o_cmd.bfs_init = 1'b1;
                n_state        = S_POP;
            end
            S_POP: begin
                if (i_sts.q_more) begin
                    o_cmd.q_rd = 1'b1;
                    n_state    = S_QWAIT;
                end else if (i_sts.snk_found) begin
                    o_cmd.aug_init = 1'b1;
                    n_state        = S_PRD;
                end else begin
                    o_cmd.res_good = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_QWAIT: begin
                o_cmd.scan_start = 1'b1;
                n_state          = S_ERD;
            end
            S_ERD: begin
                o_cmd.edge_rd = 1'b1;
                n_state       = S_ECHK;
            end
            S_ECHK: begin
                o_cmd.edge_chk = 1'b1;
                n_state        = i_sts.scan_last ? S_POP : S_ERD;
            end
            S_PRD: begin
                o_cmd.par_rd = 1'b1;
                n_state      = S_PWAIT;
            end
            S_PWAIT: begin
                o_cmd.res_rd = 1'b1;
                n_state      = S_MIN;
            end
            S_MIN: begin
                o_cmd.res_min = 1'b1;
                n_state       = i_sts.par_src ? S_URD : S_PRD;
            end
            S_URD: begin
                o_cmd.par_rd = 1'b1;
                n_state      = S_UF1;
            end
            S_UF1: begin
                o_cmd.upd_rd1 = 1'b1;
                n_state       = S_UF2;
            end
            S_UF2: begin
                o_cmd.upd_wr1 = 1'b1;
                n_state       = S_UF3;
            end
            S_UF3: begin
                o_cmd.upd_wr2 = 1'b1;
                if (i_sts.par_src) begin
                    o_cmd.tot_add = 1'b1;
                    n_state       = S_BINIT;
                end else begin
                    n_state = S_URD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLRC;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

/* rtl/core/mfba_dp.sv */
// Datapath of the max flow block: capacity, flow, parent and queue memories.
module mfba_dp
    import mfba_pkg::*;
#(
    parameter int MAX_VERTICES = 16,
    parameter int CAP_BITS     = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_req    i_req,
    input  logic [4:0] i_vcount,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    output t_out_rsp   o_rsp
);

    localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int AW    = 2 * VW;
    localparam int DEPTH = 1 << AW;
    localparam int VDEP  = 1 << VW;
    localparam int NW    = VW + 1;
    localparam int FW    = CAP_BITS + 2;
    localparam int RW    = CAP_BITS + 3;
    localparam int TW    = CAP_BITS + VW + 1;
    localparam int XW    = (TW > OUT_FLOW_BITS) ? TW : OUT_FLOW_BITS;

    logic [CAP_BITS-1:0] mem_cap  [DEPTH];
    logic [FW-1:0]       mem_flow [DEPTH];
    logic [VW-1:0]       mem_par  [VDEP];
    logic [VW-1:0]       mem_q    [VDEP];

    logic [AW-1:0]       r_clr;
    logic [VW-1:0]       r_src, r_snk, r_here, r_there, r_p, r_par;
    logic [NW-1:0]       r_n, r_head, r_tail;
    logic [MAX_VERTICES-1:0] r_visited;
    logic [FW-1:0]       r_amount;
    logic [TW-1:0]       r_total;
    logic [CAP_BITS-1:0] r_cap_q;
    logic [FW-1:0]       r_flow_q;
    logic [VW-1:0]       r_par_q, r_q_q;
    t_out_rsp            r_rsp;

    logic [VW-1:0]       w_from, w_to, w_sv, w_kv;
    logic [NW-1:0]       w_n;
    logic                w_bad, w_wr_ok;
    logic                w_cap_we, w_cap_re, w_flow_we, w_flow_re;
    logic [AW-1:0]       w_cap_wa, w_cap_ra, w_flow_wa, w_flow_ra;
    logic [CAP_BITS-1:0] w_cap_wd;
    logic [FW-1:0]       w_flow_wd;
    logic [RW-1:0]       w_res;
    logic                w_res_pos, w_take, w_tail_room;
    logic [FW:0]         w_fl_ext, w_add, w_sub;

    assign w_from = VW'(i_req.edge_from);
    assign w_to   = VW'(i_req.edge_to);
    assign w_sv   = VW'(i_req.source_vertex);
    assign w_kv   = VW'(i_req.sink_vertex);
    assign w_n    = (int'(i_vcount) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(i_vcount);
    assign w_bad  = (i_req.source_vertex == i_req.sink_vertex)
                 || (int'(i_req.source_vertex) >= int'(w_n))
                 || (int'(i_req.sink_vertex) >= int'(w_n));
    assign w_wr_ok = (int'(i_req.edge_from) < MAX_VERTICES)
                  && (int'(i_req.edge_to) < MAX_VERTICES);

    assign w_res     = {3'b000, r_cap_q} - {r_flow_q[FW-1], r_flow_q};
    assign w_res_pos = !w_res[RW-1] && (|w_res);
    assign w_take    = !r_visited[r_there] && w_res_pos;
    assign w_tail_room = int'(r_tail) < MAX_VERTICES;
    assign w_fl_ext  = {r_flow_q[FW-1], r_flow_q};
    assign w_add     = w_fl_ext + {1'b0, r_amount};
    assign w_sub     = w_fl_ext - {1'b0, r_amount};

    always_comb begin
        w_cap_we = 1'b0;
        w_cap_wa = r_clr;
        w_cap_wd = '0;
        if (i_cmd.clr_cap_step) begin
            w_cap_we = 1'b1;
        end else if (i_cmd.cap_wr && w_wr_ok) begin
            w_cap_we = 1'b1;
            w_cap_wa = {w_from, w_to};
            w_cap_wd = CAP_BITS'(i_req.edge_capacity);
        end
        w_cap_re = i_cmd.edge_rd || i_cmd.res_rd;
        w_cap_ra = i_cmd.res_rd ? {r_par_q, r_p} : {r_here, r_there};

        w_flow_we = i_cmd.clr_flow_step || i_cmd.upd_wr1 || i_cmd.upd_wr2;
        w_flow_wa = r_clr;
        w_flow_wd = '0;
        if (i_cmd.upd_wr1) begin
            w_flow_wa = {r_par, r_p};
            w_flow_wd = w_add[FW-1:0];
        end else if (i_cmd.upd_wr2) begin
            w_flow_wa = {r_p, r_par};
            w_flow_wd = w_sub[FW-1:0];
        end
        w_flow_re = i_cmd.edge_rd || i_cmd.res_rd || i_cmd.upd_rd1 || i_cmd.upd_wr1;
        w_flow_ra = {r_here, r_there};
        if (i_cmd.res_rd || i_cmd.upd_rd1) begin
            w_flow_ra = {r_par_q, r_p};
        end else if (i_cmd.upd_wr1) begin
            w_flow_ra = {r_p, r_par};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cap_we) begin
            mem_cap[w_cap_wa] <= w_cap_wd;
        end
        if (w_cap_re) begin
            r_cap_q <= mem_cap[w_cap_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_flow_we) begin
            mem_flow[w_flow_wa] <= w_flow_wd;
        end
        if (w_flow_re) begin
            r_flow_q <= mem_flow[w_flow_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bfs_init) begin
            mem_par[r_src] <= r_src;
        end else if (i_cmd.edge_chk && w_take) begin
            mem_par[r_there] <= r_here;
        end
        if (i_cmd.par_rd) begin
            r_par_q <= mem_par[r_p];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bfs_init) begin
            mem_q[VW'(0)] <= r_src;
        end else if (i_cmd.edge_chk && w_take && w_tail_room) begin
            mem_q[r_tail[VW-1:0]] <= r_there;
        end
        if (i_cmd.q_rd) begin
            r_q_q <= mem_q[r_head[VW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_start) begin
            r_clr <= '0;
        end else if (i_cmd.clr_cap_step || i_cmd.clr_flow_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_start) begin
            r_src   <= w_sv;
            r_snk   <= w_kv;
            r_n     <= w_n;
            r_total <= '0;
        end
        if (i_cmd.bfs_init) begin
            r_visited <= MAX_VERTICES'(1) << r_src;
            r_head    <= '0;
            r_tail    <= NW'(1);
        end
        if (i_cmd.q_rd) begin
            r_head <= r_head + 1'b1;
        end
        if (i_cmd.scan_start) begin
            r_here  <= r_q_q;
            r_there <= '0;
        end
        if (i_cmd.edge_chk) begin
            r_there <= r_there + 1'b1;
            if (w_take) begin
                r_visited[r_there] <= 1'b1;
                if (w_tail_room) begin
                    r_tail <= r_tail + 1'b1;
                end
            end
        end
        if (i_cmd.aug_init) begin
            r_p      <= r_snk;
            r_amount <= '1;
        end
        if (i_cmd.res_rd || i_cmd.upd_rd1) begin
            r_par <= r_par_q;
        end
        if (i_cmd.res_min) begin
            if (w_res[FW-1:0] < r_amount) begin
                r_amount <= w_res[FW-1:0];
            end
            r_p <= (r_par == r_src) ? r_snk : r_par;
        end
        if (i_cmd.upd_wr2) begin
            r_p <= r_par;
        end
        if (i_cmd.tot_add) begin
            r_total <= r_total + TW'(r_amount);
        end
        if (i_cmd.res_good) begin
            r_rsp.bad_request <= 1'b0;
            if (XW'(r_total) > XW'(OUT_FLOW_MAX)) begin
                r_rsp.max_flow <= OUT_FLOW_MAX;
            end else begin
                r_rsp.max_flow <= OUT_FLOW_BITS'(r_total);
            end
        end
        if (i_cmd.res_bad) begin
            r_rsp.bad_request <= 1'b1;
            r_rsp.max_flow    <= '0;
        end
    end

    assign o_sts.clr_last  = &r_clr;
    assign o_sts.q_more    = (r_head < r_tail) && !r_visited[r_snk];
    assign o_sts.snk_found = r_visited[r_snk];
    assign o_sts.scan_last = ({1'b0, r_there} == (r_n - 1'b1));
    assign o_sts.par_src   = (r_par == r_src);
    assign o_sts.req_bad   = w_bad;
    assign o_sts.in_flow   = (i_req.cmd == CMD_FLOW);
    assign o_rsp           = r_rsp;

endmodule

/* rtl/core/max_flow_bfs_augment_top.sv */
// Maximum flow over a capacity matrix by repeated breadth-first search; a
// write request loads one capacity entry, and a compute request names source
// and sink and returns one result with the saturated total flow, or a
// bad_request flag with zero flow when source equals sink or a vertex is not
// below vertex_count (capped at MAX_VERTICES). After reset the capacity memory
// is cleared, all 2**(2*clog2(MAX_VERTICES)) entries (256 by default), before
// requests are taken. A compute first clears the flow memory the same way, then
// per search scans the edges of each dequeued vertex to every vertex in use
// (one shared read port of the capacity and flow memories), and per augmenting
// path walks the parent chain to find the bottleneck and again to update flows.
`include "max_flow_bfs_augment_top_defines.svh"
module max_flow_bfs_augment_top
    import mfba_pkg::*;
#(
    parameter int MAX_VERTICES = 16,
    parameter int CAP_BITS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_req     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_rsp    o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [4:0] r_vcount;
    t_cmd       w_cmd;
    t_sts       w_sts;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_VCOUNT) ? {27'd0, r_vcount} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VCOUNT_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_VCOUNT) begin
            r_vcount <= pwdata[4:0];
        end
    end

    mfba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    mfba_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .CAP_BITS     (CAP_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_in_data),
        .i_vcount (r_vcount),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_rsp    (o_out_data)
    );

    `MFBA_ASSERT_IMP(a_flow_needs_free_slot,
        i_in_valid && !o_in_stall && i_in_data.cmd == CMD_FLOW, !o_out_valid,
        "compute request taken while a result waits")
    `MFBA_ASSERT_IMP(a_bad_has_zero_flow,
        o_out_valid && o_out_data.bad_request, o_out_data.max_flow == '0,
        "rejected request carries nonzero flow")
    `MFBA_ASSERT_ALWAYS(a_cap_write_on_accept,
        !w_cmd.cap_wr || (i_in_valid && !o_in_stall && i_in_data.cmd == CMD_WRITE),
        "capacity write without an accepted write request")

endmodule
